// ===== design/bbc_pkg.sv =====
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int unsigned MAX_DEPTH = 64;
  localparam int unsigned ADDR_W    = $clog2(MAX_DEPTH);
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_CURLY  = 2'd1,
    KIND_SQUARE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CLOSE_EMPTY = 3'd1,
    ST_MISMATCH    = 3'd2,
    ST_UNCLOSED    = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_t;

  typedef struct packed {
    logic    balanced;
    status_e status;
  } out_t;

  typedef struct packed {
    op_e   op;
    kind_e kind;
  } class_t;

  function automatic class_t classify(logic [7:0] c);
    class_t r;
    r.op   = OP_NONE;
    r.kind = KIND_ROUND;
    unique case (c)
      CH_OPEN_ROUND: begin
        r.op = OP_PUSH; r.kind = KIND_ROUND;
      end
      CH_OPEN_CURLY: begin
        r.op = OP_PUSH; r.kind = KIND_CURLY;
      end
      CH_OPEN_SQUARE: begin
        r.op = OP_PUSH; r.kind = KIND_SQUARE;
      end
      CH_CLOSE_ROUND: begin
        r.op = OP_POP; r.kind = KIND_ROUND;
      end
      CH_CLOSE_CURLY: begin
        r.op = OP_POP; r.kind = KIND_CURLY;
      end
      CH_CLOSE_SQUARE: begin
        r.op = OP_POP; r.kind = KIND_SQUARE;
      end
      default: begin
        r.op = OP_NONE; r.kind = KIND_ROUND;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/bracket_balance_checker_unit.sv =====
`timescale 1ns / 1ps

// Checks a byte string, one byte per request, for balanced round, curly and
// square brackets, and returns one result on the request flagged last. A new
// byte is taken every cycle; the only stall comes when a finished result is
// still held in the output register and not taken, and a second last byte
// reaches the check stage. On entry a byte updates the depth and issues the
// single push or pop on the one-port stack memory (MAX_DEPTH entries); the
// check stage compares the popped kind, which arrives as the memory's
// registered read data, and resolves the status. A push always lands before
// any later pop can read that entry, so no forwarding is needed.
// After an error the rest of the string is ignored; the first byte of the next
// string may follow the last byte directly, unless the stall above holds it.
module bracket_balance_checker_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bbc_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bbc_pkg::out_t out_rsp_o
);
  import bbc_pkg::*;

  kind_e stack_mem [MAX_DEPTH];
  kind_e rd_kind_q;

  logic [DEPTH_W-1:0] depth_q, depth_d;
  status_e err_q, err_d;

  // Check stage.
  logic    s2_valid_q, s2_valid_d;
  logic    s2_pop_q;
  kind_e   s2_kind_q;
  logic    s2_last_q;
  status_e s2_err_q;
  logic    s2_nz_q;

  logic    out_valid_q, out_valid_d;
  out_t    out_q;

  class_t  cls;
  logic    in_fire;
  logic    s2_stuck;
  logic    s2_done_last;
  logic    mismatch;
  status_e s2_err_final;
  status_e err_cur;
  status_e err_new;
  status_e final_status;
  logic    do_push;
  logic    do_pop;
  logic    full;
  logic    empty;
  logic [DEPTH_W-1:0] depth_dec;
  logic [DEPTH_W-1:0] depth_post;

  assign cls       = classify(in_req_i.char_in);
  assign s2_stuck  = s2_valid_q && s2_last_q && out_valid_q && !out_ready_i;
  assign in_ready_o = !s2_stuck;
  assign in_fire   = in_valid_i && in_ready_o;
  assign s2_done_last = s2_valid_q && s2_last_q && !s2_stuck;

  assign full      = (depth_q == DEPTH_W'(MAX_DEPTH));
  assign empty     = (depth_q == '0);
  assign depth_dec = depth_q - DEPTH_W'(1);

  always_comb begin
    mismatch = s2_valid_q && s2_pop_q && (s2_err_q == ST_OK) && (rd_kind_q != s2_kind_q);
    if (s2_err_q != ST_OK) begin
      s2_err_final = s2_err_q;
    end else if (mismatch) begin
      s2_err_final = ST_MISMATCH;
    end else begin
      s2_err_final = ST_OK;
    end

    // Error seen by the byte entering now, including the older byte's check.
    if (s2_valid_q) begin
      err_cur = s2_last_q ? ST_OK : s2_err_final;
    end else begin
      err_cur = err_q;
    end

    do_push    = 1'b0;
    do_pop     = 1'b0;
    err_new    = err_cur;
    depth_post = depth_q;
    if (in_fire && (err_cur == ST_OK)) begin
      unique case (cls.op)
        OP_PUSH: begin
          if (full) begin
            err_new = ST_OVERFLOW;
          end else begin
            do_push    = 1'b1;
            depth_post = depth_q + DEPTH_W'(1);
          end
        end
        OP_POP: begin
          if (empty) begin
            err_new = ST_CLOSE_EMPTY;
          end else begin
            do_pop     = 1'b1;
            depth_post = depth_dec;
          end
        end
        default: begin
          depth_post = depth_q;
        end
      endcase
    end

    depth_d = depth_q;
    if (in_fire) begin
      depth_d = in_req_i.last ? '0 : depth_post;
    end

    err_d = err_q;
    if (s2_valid_q && !s2_stuck) begin
      err_d = s2_last_q ? ST_OK : s2_err_final;
    end

    s2_valid_d = s2_stuck ? s2_valid_q : in_fire;

    if (s2_err_final != ST_OK) begin
      final_status = s2_err_final;
    end else if (s2_nz_q) begin
      final_status = ST_UNCLOSED;
    end else begin
      final_status = ST_OK;
    end

    out_valid_d = out_valid_q;
    if (s2_done_last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      err_q       <= ST_OK;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      err_q       <= err_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s2_pop_q  <= do_pop;
      s2_kind_q <= cls.kind;
      s2_last_q <= in_req_i.last;
      s2_err_q  <= err_new;
      s2_nz_q   <= (depth_post != '0);
    end
    if (s2_done_last) begin
      out_q.balanced <= (final_status == ST_OK);
      out_q.status   <= final_status;
    end
  end

  // Stack memory: one access per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      stack_mem[depth_q[ADDR_W-1:0]] <= cls.kind;
    end
    if (do_pop) begin
      rd_kind_q <= stack_mem[depth_dec[ADDR_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
